FILE: rtl/core/ipv6_lpt_pkg.sv
// ----------------------------------------------------------------------------
// ipv6_lpt_pkg
// Shared constants, codes and controller command type for the IPv6 route table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6_lpt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

  // field widths
  localparam int HALF_W = 64;
  localparam int ADDR_W = 2 * HALF_W;
  localparam int PORT_W = 16;

  // entry layout in the route RAM: {prefix, mask, hop, port}
  localparam int ENTRY_W = 3 * ADDR_W + PORT_W;
  localparam int PORT_LSB = 0;
  localparam int HOP_LSB = PORT_W;
  localparam int MASK_LSB = PORT_W + ADDR_W;
  localparam int PFX_LSB = PORT_W + 2 * ADDR_W;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic             load;     // capture the incoming word
    logic             rd_en;    // read one slot from the route RAM
    logic [IDX_W-1:0] rd_addr;
    logic             cmp_en;   // RAM data for cmp_idx is valid this cycle
    logic [IDX_W-1:0] cmp_idx;
    logic             finish;   // commit add and register the result
  } lpt_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/ipv6_longest_prefix_table.sv
// ----------------------------------------------------------------------------
// ipv6_longest_prefix_table
// IPv6 route table with linear longest-prefix lookup, route add and delete.
//
// Channel   Dir  Handshake            Payload
// command   in   start, busy          op, addr_hi/lo, netmask_hi/lo,
//                                     gateway_hi/lo, port_in
// result    out  done (1-cycle strobe) status, next_hop_hi/lo, port_out
//
// A word is taken when start is high and busy is low. Every word walks all
// TABLE_ENTRIES slots of the route RAM, one slot read per cycle. Busy stays
// high until the commit, so no new word is taken before the last is through;
// done is registered from the commit state (S_DONE).
// Reset (rst, synchronous) empties the table at once; valid bits are flops.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_longest_prefix_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       op,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]  addr_hi,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]  addr_lo,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]  netmask_hi,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]  netmask_lo,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]  gateway_hi,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]  gateway_lo,
  input  wire logic [ipv6_lpt_pkg::PORT_W-1:0]  port_in,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [ipv6_lpt_pkg::HALF_W-1:0]       next_hop_hi,
  output logic [ipv6_lpt_pkg::HALF_W-1:0]       next_hop_lo,
  output logic [ipv6_lpt_pkg::PORT_W-1:0]       port_out
);

  ipv6_lpt_pkg::lpt_cmd_t cmd;

  // sequencer
  ipv6_lpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // table and compare datapath
  ipv6_lpt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .addr_hi     (addr_hi),
    .addr_lo     (addr_lo),
    .netmask_hi  (netmask_hi),
    .netmask_lo  (netmask_lo),
    .gateway_hi  (gateway_hi),
    .gateway_lo  (gateway_lo),
    .port_in     (port_in),
    .done        (done),
    .status      (status),
    .next_hop_hi (next_hop_hi),
    .next_hop_lo (next_hop_lo),
    .port_out    (port_out)
  );

`ifndef SYNTHESIS
  // an accepted word always starts a scan
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // words are captured only while idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy)
    else $error("datapath load while busy");

  // every commit yields one result strobe
  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done)
    else $error("commit without result strobe");

  // no compare or RAM read outside a scan
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en || cmd.cmp_en) |-> busy)
    else $error("scan activity while idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ipv6_lpt_ram.sv
// ----------------------------------------------------------------------------
// ipv6_lpt_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_lpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [ADDR_BITS-1:0]   waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [ADDR_BITS-1:0]   raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipv6_lpt_ctrl.sv
// ----------------------------------------------------------------------------
// ipv6_lpt_ctrl
// Sequencer for the route table: walks every slot once per word, then commits.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_lpt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output ipv6_lpt_pkg::lpt_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  state_t                         state;
  logic [ipv6_lpt_pkg::IDX_W-1:0] slot;
  logic                           cmp_en;
  logic [ipv6_lpt_pkg::IDX_W-1:0] cmp_idx;

  // state, slot counter and compare pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      slot   <= '0;
      cmp_en <= 1'b0;
    end else begin
      // RAM read data lands in the cycle after the address
      cmp_en  <= (state == S_SCAN);
      cmp_idx <= slot;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            slot  <= '0;
          end
        end
        S_SCAN: begin
          if (slot == ipv6_lpt_pkg::LAST_SLOT) begin
            state <= S_LAST;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_LAST: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // commands
  always_comb begin
    busy        = (state != S_IDLE);
    cmd.load    = (state == S_IDLE) && start;
    cmd.rd_en   = (state == S_SCAN);
    cmd.rd_addr = slot;
    cmd.cmp_en  = cmp_en;
    cmd.cmp_idx = cmp_idx;
    cmd.finish  = (state == S_DONE);
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipv6_lpt_dp.sv
// ----------------------------------------------------------------------------
// ipv6_lpt_dp
// Route table datapath: valid bits, route RAM, per-slot compare and result.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_lpt_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ipv6_lpt_pkg::lpt_cmd_t              cmd,
  input  wire logic [1:0]                          op,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]     addr_hi,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]     addr_lo,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]     netmask_hi,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]     netmask_lo,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]     gateway_hi,
  input  wire logic [ipv6_lpt_pkg::HALF_W-1:0]     gateway_lo,
  input  wire logic [ipv6_lpt_pkg::PORT_W-1:0]     port_in,
  output logic                                     done,
  output logic [1:0]                               status,
  output logic [ipv6_lpt_pkg::HALF_W-1:0]          next_hop_hi,
  output logic [ipv6_lpt_pkg::HALF_W-1:0]          next_hop_lo,
  output logic [ipv6_lpt_pkg::PORT_W-1:0]          port_out
);

  localparam int AW = ipv6_lpt_pkg::ADDR_W;
  localparam int PW = ipv6_lpt_pkg::PORT_W;
  localparam int IW = ipv6_lpt_pkg::IDX_W;
  localparam int EW = ipv6_lpt_pkg::ENTRY_W;

  // captured word
  logic [1:0]    op_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] mask_q;
  logic [AW-1:0] net_q;
  logic [AW-1:0] gw_q;
  logic [PW-1:0] port_q;

  // scan results
  logic          best_found;
  logic [AW-1:0] best_mask;
  logic [AW-1:0] best_hop;
  logic [PW-1:0] best_port;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [ipv6_lpt_pkg::TABLE_ENTRIES-1:0] slot_valid;

  // route RAM
  logic          ram_we;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  ipv6_lpt_ram #(
    .WIDTH (EW),
    .DEPTH (ipv6_lpt_pkg::TABLE_ENTRIES)
  ) u_route_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (ram_rdata)
  );

  // slot fields of the entry under compare
  logic [AW-1:0] e_pfx;
  logic [AW-1:0] e_mask;
  logic [AW-1:0] e_hop;
  logic [PW-1:0] e_port;
  logic          e_valid;
  logic          hit;
  logic          covers;
  logic          dup;

  always_comb begin
    e_pfx   = ram_rdata[ipv6_lpt_pkg::PFX_LSB +: AW];
    e_mask  = ram_rdata[ipv6_lpt_pkg::MASK_LSB +: AW];
    e_hop   = ram_rdata[ipv6_lpt_pkg::HOP_LSB +: AW];
    e_port  = ram_rdata[ipv6_lpt_pkg::PORT_LSB +: PW];
    e_valid = slot_valid[cmd.cmp_idx];
    // lookup: prefix match, and mask at least as long as the current best
    hit     = e_valid && ((addr_q & e_mask) == e_pfx);
    covers  = !best_found || ((e_mask & best_mask) == best_mask);
    // add / delete: exact network and mask match
    dup     = e_valid && (e_pfx == net_q) && (e_mask == mask_q);
  end

  // add commit
  always_comb begin
    ram_we    = cmd.finish && (op_q == ipv6_lpt_pkg::OP_ADD) && free_found;
    ram_wdata = {net_q, mask_q, gw_q, port_q};
  end

  // captured word registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      addr_q <= {addr_hi, addr_lo};
      mask_q <= {netmask_hi, netmask_lo};
      net_q  <= {addr_hi, addr_lo} & {netmask_hi, netmask_lo};
      gw_q   <= {gateway_hi, gateway_lo};
      port_q <= port_in;
    end
  end

  // scan bookkeeping and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      free_found <= 1'b0;
      slot_valid <= '0;
    end else if (cmd.load) begin
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.cmp_en) begin
      case (op_q)
        ipv6_lpt_pkg::OP_LOOKUP: begin
          if (hit && covers) begin
            best_found <= 1'b1;
            best_mask  <= e_mask;
            best_hop   <= e_hop;
            best_port  <= e_port;
          end
        end
        ipv6_lpt_pkg::OP_ADD: begin
          if (dup) begin
            slot_valid[cmd.cmp_idx] <= 1'b0;
          end
          // first slot free once duplicates are gone
          if ((!e_valid || dup) && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmd.cmp_idx;
          end
        end
        ipv6_lpt_pkg::OP_DELETE: begin
          if (dup) begin
            slot_valid[cmd.cmp_idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (ram_we) begin
      slot_valid[free_idx] <= 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (op_q)
        ipv6_lpt_pkg::OP_LOOKUP: begin
          if (best_found) begin
            status      <= ipv6_lpt_pkg::ST_OK;
            next_hop_hi <= best_hop[AW-1 -: ipv6_lpt_pkg::HALF_W];
            next_hop_lo <= best_hop[ipv6_lpt_pkg::HALF_W-1:0];
            port_out    <= best_port;
          end else begin
            status      <= ipv6_lpt_pkg::ST_MISS;
            next_hop_hi <= '0;
            next_hop_lo <= '0;
            port_out    <= '0;
          end
        end
        ipv6_lpt_pkg::OP_ADD: begin
          status      <= free_found ? ipv6_lpt_pkg::ST_OK : ipv6_lpt_pkg::ST_FULL;
          next_hop_hi <= '0;
          next_hop_lo <= '0;
          port_out    <= '0;
        end
        default: begin
          status      <= ipv6_lpt_pkg::ST_OK;
          next_hop_hi <= '0;
          next_hop_lo <= '0;
          port_out    <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
